// ----- sv/gms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gantry motion sequencer package
// Shared widths, reset defaults and command codes of the slider sequencer.
// ----------------------------------------------------------------------------
package gms_pkg;

   // Field widths of the channels and the register port
   localparam int OP_WIDTH        = 3;
   localparam int MODE_WIDTH      = 3;
   localparam int NOW_WIDTH       = 32;
   localparam int REMAIN_WIDTH    = 16;
   localparam int WAIT_WIDTH      = 31;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 31;

   // Default parameter values
   localparam int FIXED_TRAVEL_DEFAULT = 1000;
   localparam int DIST_BITS_DEFAULT    = 16;
   localparam int TIME_BITS_DEFAULT    = 32;

   // Register reset values
   localparam logic [15:0] TRAVEL_RESET    = 16'd1000;
   localparam logic [15:0] CHUNK_RESET     = 16'd10;
   localparam logic [30:0] INTERVAL_RESET  = 31'd5000;
   localparam logic        TIMELAPSE_RESET = 1'b1;
   localparam logic        BASE_DIR_RESET  = 1'b1;

   // Command codes
   typedef enum logic [OP_WIDTH-1:0] {
      OP_SPIN  = 3'd0,
      OP_START = 3'd1,
      OP_HOME  = 3'd2,
      OP_MOVE  = 3'd3,
      OP_STOP  = 3'd4
   } op_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TRAVEL    = 3'd0,
      CSR_CHUNK     = 3'd1,
      CSR_INTERVAL  = 3'd2,
      CSR_TIMELAPSE = 3'd3,
      CSR_BASE_DIR  = 3'd4
   } csr_index_type;

   // One result transaction
   typedef struct packed {
      logic [MODE_WIDTH-1:0]   mode;
      logic                    forward;
      logic                    step_request;
      logic                    shutter;
      logic                    stopped;
      logic [REMAIN_WIDTH-1:0] remaining_mm;
      logic [WAIT_WIDTH-1:0]   wait_left_ms;
   } rsp_type;

endpackage

// ----- sv/gms_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gantry request channel
// Valid/ready channel that carries one spin or command transaction.
// ----------------------------------------------------------------------------
interface gms_req_if;
   import gms_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_WIDTH-1:0]   operation;
   logic                  move_forward;
   logic                  end_stop_a;
   logic                  end_stop_b;
   logic [NOW_WIDTH-1:0]  now_ms;

   modport source (
      output valid, operation, move_forward, end_stop_a, end_stop_b, now_ms,
      input  ready
   );

   modport sink (
      input  valid, operation, move_forward, end_stop_a, end_stop_b, now_ms,
      output ready
   );
endinterface

// ----- sv/gms_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gantry response channel
// Valid/ready channel that carries one sequencer status transaction.
// ----------------------------------------------------------------------------
interface gms_rsp_if;
   import gms_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MODE_WIDTH-1:0]   mode;
   logic                    forward;
   logic                    step_request;
   logic                    shutter;
   logic                    stopped;
   logic [REMAIN_WIDTH-1:0] remaining_mm;
   logic [WAIT_WIDTH-1:0]   wait_left_ms;

   modport source (
      output valid, mode, forward, step_request, shutter, stopped,
             remaining_mm, wait_left_ms,
      input  ready
   );

   modport sink (
      input  valid, mode, forward, step_request, shutter, stopped,
             remaining_mm, wait_left_ms,
      output ready
   );
endinterface

// ----- sv/gantry_motion_sequencer.sv -----
`timescale 1ns / 1ps
// Data path: a request transaction is held in the input register, then its response
//    in the response register, which drives the response channel.
// Throughput: one transaction per cycle while responses are taken; all mode, step and timer
//    logic sits in a single combinational pass between the input and response registers.
// Reset (synchronous): mode idle, direction forward, counters and timer cleared,
//    configuration registers back to their defaults, both stages empty.
// ----------------------------------------------------------------------------
// Gantry motion sequencer
// Mode control for a camera slider: time-lapse, run, homing and manual move.
// ----------------------------------------------------------------------------
module gantry_motion_sequencer #(
   parameter int FIXED_TRAVEL_MM = gms_pkg::FIXED_TRAVEL_DEFAULT,
   parameter int DIST_BITS       = gms_pkg::DIST_BITS_DEFAULT,
   parameter int TIME_BITS       = gms_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gms_req_if.sink                              req_bus,
   gms_rsp_if.source                            rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [gms_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gms_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import gms_pkg::*;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_IDLE      = 3'd0,
      MODE_TIMELAPSE = 3'd1,
      MODE_RUN       = 3'd2,
      MODE_HOME      = 3'd3,
      MODE_MOVE      = 3'd4
   } mode_type;

   // Configuration registers
   logic [15:0]          travel_cfg_ff;
   logic [15:0]          chunk_cfg_ff;
   logic [30:0]          interval_cfg_ff;
   logic                 timelapse_cfg_ff;
   logic                 base_dir_cfg_ff;

   // Input stage
   logic                 in_valid_ff, in_valid_in;
   logic [OP_WIDTH-1:0]  op_ff;
   logic                 move_fwd_ff;
   logic                 stop_a_ff;
   logic                 stop_b_ff;
   logic [TIME_BITS-1:0] now_ff;

   // Sequencer state
   mode_type             mode_ff, mode_in;
   logic                 dir_now_ff, dir_now_in;
   logic                 dir_saved_ff, dir_saved_in;
   logic [DIST_BITS-1:0] travel_ff, travel_in;
   logic [DIST_BITS-1:0] chunk_ff, chunk_in;
   logic                 chunk_active_ff, chunk_active_in;
   logic [TIME_BITS-1:0] last_time_ff, last_time_in;

   // Response stage
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Working signals
   logic                 req_take;
   logic                 advance;
   logic                 halt;
   logic                 step_req;
   logic                 shutter;
   logic [TIME_BITS-1:0] interval;
   logic [TIME_BITS-1:0] due_diff;
   logic [TIME_BITS-1:0] wait_diff;

   // Handshake: the input stage moves on whenever the response slot frees up
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   assign interval  = TIME_BITS'(interval_cfg_ff);
   assign due_diff  = now_ff - last_time_ff - interval;
   assign wait_diff = last_time_in + interval - now_ff;

   // Advance the sequencer by one transaction
   always_comb begin
      mode_in         = mode_ff;
      dir_now_in      = dir_now_ff;
      dir_saved_in    = dir_saved_ff;
      travel_in       = travel_ff;
      chunk_in        = chunk_ff;
      chunk_active_in = chunk_active_ff;
      last_time_in    = last_time_ff;
      halt            = 1'b0;
      step_req        = 1'b0;
      shutter         = 1'b0;

      if (advance) begin
         // Idle machine follows the configured direction
         if (mode_ff == MODE_IDLE) begin
            dir_now_in   = base_dir_cfg_ff;
            dir_saved_in = base_dir_cfg_ff;
         end

         unique case (op_ff)
            OP_SPIN: begin
               if (stop_a_ff || stop_b_ff) begin
                  halt = (mode_ff != MODE_IDLE);
               end else if (mode_ff == MODE_TIMELAPSE) begin
                  // Rearm the chunk once the interval has run out
                  if (chunk_active_ff || !due_diff[TIME_BITS-1]) begin
                     if (chunk_ff != '0) begin
                        step_req  = 1'b1;
                        chunk_in  = chunk_ff - 1'b1;
                        if (travel_ff != '0) begin
                           travel_in = travel_ff - 1'b1;
                        end
                        chunk_active_in = 1'b1;
                     end else begin
                        shutter         = 1'b1;
                        chunk_active_in = 1'b0;
                        last_time_in    = now_ff;
                        chunk_in        = DIST_BITS'(chunk_cfg_ff);
                     end
                  end
                  if (travel_in == '0) begin
                     halt = 1'b1;
                  end
               end else if (mode_ff != MODE_IDLE) begin
                  if (travel_ff != '0) begin
                     step_req  = 1'b1;
                     travel_in = travel_ff - 1'b1;
                  end else begin
                     halt = 1'b1;
                  end
               end
            end
            OP_START: begin
               mode_in         = timelapse_cfg_ff ? MODE_TIMELAPSE : MODE_RUN;
               chunk_in        = DIST_BITS'(chunk_cfg_ff);
               chunk_active_in = 1'b1;
               travel_in       = DIST_BITS'(travel_cfg_ff);
               dir_saved_in    = dir_now_in;
               last_time_in    = now_ff;
            end
            OP_HOME: begin
               mode_in      = MODE_HOME;
               travel_in    = DIST_BITS'(FIXED_TRAVEL_MM);
               dir_saved_in = dir_now_in;
               dir_now_in   = !dir_now_in;
            end
            OP_MOVE: begin
               mode_in      = MODE_MOVE;
               travel_in    = DIST_BITS'(FIXED_TRAVEL_MM);
               dir_saved_in = dir_now_in;
               dir_now_in   = move_fwd_ff;
            end
            OP_STOP: begin
               halt = 1'b1;
            end
            default: begin
            end
         endcase

         // Drop to idle and restore the saved direction
         if (halt) begin
            mode_in         = MODE_IDLE;
            dir_now_in      = dir_saved_in;
            travel_in       = '0;
            chunk_in        = '0;
            chunk_active_in = 1'b0;
         end
      end
   end

   // Build the response
   always_comb begin
      rsp_in.mode         = mode_in;
      rsp_in.forward      = dir_now_in;
      rsp_in.step_request = step_req;
      rsp_in.shutter      = shutter;
      rsp_in.stopped      = halt && (mode_ff != MODE_IDLE);
      rsp_in.remaining_mm = REMAIN_WIDTH'(travel_in);
      rsp_in.wait_left_ms = '0;
      if (mode_in == MODE_TIMELAPSE && !chunk_active_in && !wait_diff[TIME_BITS-1]) begin
         rsp_in.wait_left_ms = WAIT_WIDTH'(wait_diff);
      end
   end

   // Hold control and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= MODE_IDLE;
         dir_now_ff      <= BASE_DIR_RESET;
         dir_saved_ff    <= BASE_DIR_RESET;
         travel_ff       <= '0;
         chunk_ff        <= '0;
         chunk_active_ff <= 1'b0;
         last_time_ff    <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         mode_ff         <= mode_in;
         dir_now_ff      <= dir_now_in;
         dir_saved_ff    <= dir_saved_in;
         travel_ff       <= travel_in;
         chunk_ff        <= chunk_in;
         chunk_active_ff <= chunk_active_in;
         last_time_ff    <= last_time_in;
      end
   end

   // Capture register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         travel_cfg_ff    <= TRAVEL_RESET;
         chunk_cfg_ff     <= CHUNK_RESET;
         interval_cfg_ff  <= INTERVAL_RESET;
         timelapse_cfg_ff <= TIMELAPSE_RESET;
         base_dir_cfg_ff  <= BASE_DIR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRAVEL:    travel_cfg_ff    <= csr_wdata[15:0];
            CSR_CHUNK:     chunk_cfg_ff     <= csr_wdata[15:0];
            CSR_INTERVAL:  interval_cfg_ff  <= csr_wdata;
            CSR_TIMELAPSE: timelapse_cfg_ff <= csr_wdata[0];
            CSR_BASE_DIR:  base_dir_cfg_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= req_bus.operation;
         move_fwd_ff <= req_bus.move_forward;
         stop_a_ff   <= req_bus.end_stop_a;
         stop_b_ff   <= req_bus.end_stop_b;
         now_ff      <= TIME_BITS'(req_bus.now_ms);
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mode         = rsp_ff.mode;
   assign rsp_bus.forward      = rsp_ff.forward;
   assign rsp_bus.step_request = rsp_ff.step_request;
   assign rsp_bus.shutter      = rsp_ff.shutter;
   assign rsp_bus.stopped      = rsp_ff.stopped;
   assign rsp_bus.remaining_mm = rsp_ff.remaining_mm;
   assign rsp_bus.wait_left_ms = rsp_ff.wait_left_ms;

   // A stop report always comes with an idle machine
   a_stopped_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stopped |-> rsp_ff.mode == MODE_IDLE)
      else $error("stopped reported while not idle");

   // Stepping and firing the shutter exclude each other
   a_step_shutter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.step_request && rsp_ff.shutter))
      else $error("step and shutter in the same transaction");

   // A pending wait only exists in time-lapse mode
   a_wait_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.wait_left_ms != '0 |-> rsp_ff.mode == MODE_TIMELAPSE)
      else $error("wait reported outside time-lapse");

   // An idle machine holds no travel
   a_idle_clear: assert property (@(posedge clock)
      mode_ff == MODE_IDLE |-> travel_ff == '0 && !chunk_active_ff)
      else $error("idle machine holds travel");

   // A response slot is only refilled when it was free or taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response overwritten before it was taken");

endmodule

// ----- tb/gantry_motion_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gantry motion sequencer testbench
// Drives spin and command transactions with random gaps and back-pressure,
// tracks the sequencer in a bench-side model, and checks every status
// transaction field by field across a range of register settings.
// ----------------------------------------------------------------------------
module gantry_motion_sequencer_tb;
   import gms_pkg::*;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 5;
   localparam int DRAIN_CYCLES  = 4;
   localparam int IDLE_MAX      = 10;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 60;
   localparam int DIRECTED_ROWS = 33;

   localparam logic [REMAIN_WIDTH-1:0]    FIXED_TRAVEL   = 16'(FIXED_TRAVEL_DEFAULT);
   localparam logic [OP_WIDTH-1:0]        OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_WIDTH-1:0]        OP_SPARE_LAST  = 3'd7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE      = 3'd7;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_IDLE      = 3'd0,
      MODE_TIMELAPSE = 3'd1,
      MODE_RUN       = 3'd2,
      MODE_HOMING    = 3'd3,
      MODE_MOVING    = 3'd4
   } mode_type;

   typedef enum {ROW_PREDICT, ROW_TYPED, ROW_CSR} row_kind_type;

   // code is the operation, or the register index on a register row;
   // value is now_ms, or the write data on a register row
   typedef struct {
      row_kind_type            kind;
      logic [OP_WIDTH-1:0]     code;
      logic                    mv;
      logic                    ea;
      logic                    eb;
      logic [NOW_WIDTH-1:0]    value;
      rsp_type                 want;
   } row_type;

   // Typed statuses: {mode, forward/step/shutter/stopped, remaining, wait}
   localparam rsp_type NO_STATUS      = '0;
   localparam rsp_type IDLE_FWD       = {MODE_IDLE, 4'b1000, 16'd0, 31'd0};
   localparam rsp_type START_DEFAULT  = {MODE_TIMELAPSE, 4'b1000, 16'd1000, 31'd0};
   localparam rsp_type FIRST_STEP     = {MODE_TIMELAPSE, 4'b1100, 16'd999, 31'd0};
   localparam rsp_type WAIT_SATURATED = {MODE_TIMELAPSE, 4'b0010, 16'd1, 31'h7FFF_FFFF};
   localparam rsp_type LAST_MM_STOP   = {MODE_IDLE, 4'b0101, 16'd0, 31'd0};
   localparam rsp_type RUN_DONE       = {MODE_IDLE, 4'b0001, 16'd0, 31'd0};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   gms_req_if req_bus ();
   gms_rsp_if rsp_bus ();

   // Register settings held by the bench model
   logic [15:0] cfg_travel;
   logic [15:0] cfg_chunk;
   logic [30:0] cfg_interval;
   logic        cfg_timelapse;
   logic        cfg_base_dir;

   // Sequencer state held by the bench model
   mode_type    seq_mode;
   logic        dir_now;
   logic        dir_saved;
   logic [15:0] travel_left;
   logic [15:0] chunk_left;
   logic        chunk_running;
   logic [31:0] chunk_stamp;

   rsp_type     pending_status [$];
   logic [31:0] wall_ms = '0;
   bit          steady_run = 1'b0;
   int          error_count = 0;
   int          requests_sent = 0;
   int          directed_sent = 0;
   int          settings_written = 0;
   int          responses_checked = 0;
   int          steps_seen = 0;
   int          shutters_seen = 0;
   int          stops_seen = 0;

   row_type directed_rows [DIRECTED_ROWS] = '{
      // reset state, ignored codes and end stops while idle
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd0,          IDLE_FWD},
      '{ROW_TYPED,   OP_STOP,        1'b0, 1'b0, 1'b0, 32'd1,          IDLE_FWD},
      '{ROW_TYPED,   OP_SPARE_LAST,  1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,  IDLE_FWD},
      '{ROW_TYPED,   OP_SPARE_FIRST, 1'b0, 1'b0, 1'b0, 32'd2,          IDLE_FWD},
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b1, 1'b1, 32'd3,          IDLE_FWD},
      // time-lapse from defaults, then home, end stop, move and stop
      '{ROW_TYPED,   OP_START,       1'b0, 1'b0, 1'b0, 32'd100,        START_DEFAULT},
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd100,        FIRST_STEP},
      '{ROW_PREDICT, OP_SPIN,        1'b1, 1'b0, 1'b0, 32'd101,        NO_STATUS},
      '{ROW_PREDICT, OP_HOME,        1'b0, 1'b0, 1'b0, 32'd102,        NO_STATUS},
      '{ROW_PREDICT, OP_SPIN,        1'b0, 1'b0, 1'b1, 32'd103,        NO_STATUS},
      '{ROW_PREDICT, OP_MOVE,        1'b0, 1'b0, 1'b0, 32'd104,        NO_STATUS},
      '{ROW_PREDICT, OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd105,        NO_STATUS},
      '{ROW_PREDICT, OP_MOVE,        1'b1, 1'b0, 1'b0, 32'd106,        NO_STATUS},
      '{ROW_PREDICT, OP_STOP,        1'b0, 1'b0, 1'b0, 32'd107,        NO_STATUS},
      // zero chunk distance, longest interval, reverse base direction
      '{ROW_CSR,     CSR_TRAVEL,     1'b0, 1'b0, 1'b0, 32'd1,          NO_STATUS},
      '{ROW_CSR,     CSR_CHUNK,      1'b0, 1'b0, 1'b0, 32'd0,          NO_STATUS},
      '{ROW_CSR,     CSR_INTERVAL,   1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF,  NO_STATUS},
      '{ROW_CSR,     CSR_BASE_DIR,   1'b0, 1'b0, 1'b0, 32'd0,          NO_STATUS},
      '{ROW_PREDICT, OP_START,       1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0,  NO_STATUS},
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b0, 1'b0, 32'h0000_0010,  WAIT_SATURATED},
      '{ROW_PREDICT, OP_SPIN,        1'b0, 1'b0, 1'b0, 32'h8000_0010,  NO_STATUS},
      '{ROW_PREDICT, OP_SPIN,        1'b0, 1'b0, 1'b0, 32'h8000_000F,  NO_STATUS},
      '{ROW_PREDICT, OP_STOP,        1'b0, 1'b0, 1'b0, 32'h8000_0020,  NO_STATUS},
      // last millimetre of a time-lapse stops in the same transaction
      '{ROW_CSR,     CSR_CHUNK,      1'b0, 1'b0, 1'b0, 32'd1,          NO_STATUS},
      '{ROW_PREDICT, OP_START,       1'b0, 1'b0, 1'b0, 32'd0,          NO_STATUS},
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd0,          LAST_MM_STOP},
      // continuous run ends on the spin after travel runs out
      '{ROW_CSR,     CSR_TIMELAPSE,  1'b0, 1'b0, 1'b0, 32'd0,          NO_STATUS},
      '{ROW_PREDICT, OP_START,       1'b0, 1'b0, 1'b0, 32'd5,          NO_STATUS},
      '{ROW_PREDICT, OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd6,          NO_STATUS},
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd7,          RUN_DONE},
      // unused register index changes nothing
      '{ROW_CSR,     CSR_BASE_DIR,   1'b0, 1'b0, 1'b0, 32'd1,          NO_STATUS},
      '{ROW_CSR,     CSR_SPARE,      1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,  NO_STATUS},
      '{ROW_TYPED,   OP_SPIN,        1'b0, 1'b0, 1'b0, 32'd8,          IDLE_FWD}
   };

   gantry_motion_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Bound the run in case a handshake never completes
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Return the bench model to its power-up state
   task automatic reset_sequencer();
      cfg_travel    = TRAVEL_RESET;
      cfg_chunk     = CHUNK_RESET;
      cfg_interval  = INTERVAL_RESET;
      cfg_timelapse = TIMELAPSE_RESET;
      cfg_base_dir  = BASE_DIR_RESET;
      seq_mode      = MODE_IDLE;
      dir_now       = BASE_DIR_RESET;
      dir_saved     = BASE_DIR_RESET;
      travel_left   = '0;
      chunk_left    = '0;
      chunk_running = 1'b0;
      chunk_stamp   = '0;
   endtask

   // Drop to idle and restore the saved direction; tell whether motion stopped
   function automatic logic halt_motion();
      logic was_moving;
      was_moving    = (seq_mode != MODE_IDLE);
      seq_mode      = MODE_IDLE;
      dir_now       = dir_saved;
      travel_left   = '0;
      chunk_left    = '0;
      chunk_running = 1'b0;
      return was_moving;
   endfunction

   // Apply one transaction to the model and return the status it produces
   function automatic rsp_type advance_sequencer(logic [OP_WIDTH-1:0] op, logic mv,
                                                 logic ea, logic eb, logic [31:0] now);
      rsp_type     st;
      logic [31:0] since_due;
      logic [31:0] time_to_go;
      st = '0;
      if (seq_mode == MODE_IDLE) begin
         dir_now   = cfg_base_dir;
         dir_saved = cfg_base_dir;
      end
      case (op)
         OP_SPIN: begin
            if (ea || eb) begin
               if (seq_mode != MODE_IDLE) st.stopped = halt_motion();
            end else if (seq_mode == MODE_TIMELAPSE) begin
               // wrap-safe: the chunk is due once now - stamp - interval is non-negative
               since_due = now - chunk_stamp - {1'b0, cfg_interval};
               if (!chunk_running && !since_due[31]) chunk_running = 1'b1;
               if (chunk_running) begin
                  if (chunk_left != 0) begin
                     st.step_request = 1'b1;
                     chunk_left      = chunk_left - 1'b1;
                     if (travel_left != 0) travel_left = travel_left - 1'b1;
                  end else begin
                     st.shutter    = 1'b1;
                     chunk_running = 1'b0;
                     chunk_stamp   = now;
                     chunk_left    = cfg_chunk;
                  end
               end
               if (travel_left == 0) st.stopped = halt_motion();
            end else if (seq_mode != MODE_IDLE) begin
               if (travel_left != 0) begin
                  st.step_request = 1'b1;
                  travel_left     = travel_left - 1'b1;
               end else begin
                  st.stopped = halt_motion();
               end
            end
         end
         OP_START: begin
            seq_mode      = cfg_timelapse ? MODE_TIMELAPSE : MODE_RUN;
            chunk_left    = cfg_chunk;
            chunk_running = 1'b1;
            travel_left   = cfg_travel;
            dir_saved     = dir_now;
            chunk_stamp   = now;
         end
         OP_HOME: begin
            seq_mode    = MODE_HOMING;
            travel_left = FIXED_TRAVEL;
            dir_saved   = dir_now;
            dir_now     = ~dir_now;
         end
         OP_MOVE: begin
            seq_mode    = MODE_MOVING;
            travel_left = FIXED_TRAVEL;
            dir_saved   = dir_now;
            dir_now     = mv;
         end
         OP_STOP: st.stopped = halt_motion();
         default: ;
      endcase
      // report the wait only while idling between chunks; overdue reads as zero
      if (seq_mode == MODE_TIMELAPSE && !chunk_running) begin
         time_to_go = chunk_stamp + {1'b0, cfg_interval} - now;
         if (!time_to_go[31]) st.wait_left_ms = time_to_go[30:0];
      end
      st.mode         = seq_mode;
      st.forward      = dir_now;
      st.remaining_mm = travel_left;
      return st;
   endfunction

   function automatic int draw_idle();
      return steady_run ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got %0h, expected %0h",
                                   responses_checked, name, got, want));
   endtask

   // Match one received status against the oldest outstanding expectation
   task automatic check_status(rsp_type got);
      rsp_type want;
      if (pending_status.size() == 0) begin
         report_mismatch($sformatf("status %h with no request outstanding", got));
         return;
      end
      want = pending_status.pop_front();
      responses_checked++;
      steps_seen    += int'(want.step_request);
      shutters_seen += int'(want.shutter);
      stops_seen    += int'(want.stopped);
      compare_field("mode",         32'(got.mode),         32'(want.mode));
      compare_field("forward",      32'(got.forward),      32'(want.forward));
      compare_field("step_request", 32'(got.step_request), 32'(want.step_request));
      compare_field("shutter",      32'(got.shutter),      32'(want.shutter));
      compare_field("stopped",      32'(got.stopped),      32'(want.stopped));
      compare_field("remaining_mm", 32'(got.remaining_mm), 32'(want.remaining_mm));
      compare_field("wait_left_ms", 32'(got.wait_left_ms), 32'(want.wait_left_ms));
   endtask

   // Offer one request after a random gap and log its expected status
   task automatic send_request(logic [OP_WIDTH-1:0] op, logic mv, logic ea, logic eb,
                               logic [31:0] now, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = draw_idle();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= op;
      req_bus.move_forward <= mv;
      req_bus.end_stop_a   <= ea;
      req_bus.end_stop_b   <= eb;
      req_bus.now_ms       <= now;
      do @(posedge clock); while (!req_bus.ready);
      predicted = advance_sequencer(op, mv, ea, eb, now);
      pending_status.insert(pending_status.size(), typed ? want : predicted);
      requests_sent++;
   endtask

   // Hold off requests until every status is back and the pipeline is empty
   task automatic settle_pipeline();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [30:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_TRAVEL:    cfg_travel    = data[15:0];
         CSR_CHUNK:     cfg_chunk     = data[15:0];
         CSR_INTERVAL:  cfg_interval  = data;
         CSR_TIMELAPSE: cfg_timelapse = data[0];
         CSR_BASE_DIR:  cfg_base_dir  = data[0];
         default: ;
      endcase
      settings_written++;
   endtask

   // One register setting followed by a stretch of mostly well-formed motion
   task automatic run_phase(int phase);
      logic [15:0]         travel;
      logic [15:0]         chunk;
      logic [30:0]         interval;
      logic                timelapse;
      logic                base_dir;
      logic [OP_WIDTH-1:0] op;
      logic                ea;
      logic                eb;
      int                  pick;
      int                  stride_max;
      int                  served;
      bit                  ignored;
      settle_pipeline();
      case (phase)
         0: begin
            travel = 16'd1; chunk = 16'd0; interval = 31'd0;
            timelapse = 1'b0; base_dir = 1'b0;
         end
         1: begin
            travel = 16'hFFFF; chunk = 16'hFFFF; interval = 31'h7FFF_FFFF;
            timelapse = 1'b1; base_dir = 1'b1;
         end
         default: begin
            travel    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(0, 40));
            chunk     = 16'($urandom_range(0, 8));
            interval  = ($urandom_range(0, 4) == 0) ? 31'($urandom())
                                                    : 31'($urandom_range(0, 40));
            timelapse = 1'($urandom_range(0, 1));
            base_dir  = 1'($urandom_range(0, 1));
         end
      endcase
      write_reg(CSR_TRAVEL, {15'd0, travel});
      write_reg(CSR_CHUNK, {15'd0, chunk});
      write_reg(CSR_INTERVAL, interval);
      write_reg(CSR_TIMELAPSE, {30'd0, timelapse});
      write_reg(CSR_BASE_DIR, {30'd0, base_dir});
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, 31'($urandom()));

      steady_run = (phase % 3 == 2);
      stride_max = (cfg_interval < 31'd64) ? int'(cfg_interval) / 2 + 3 : 400;
      if (phase % 4 == 3) wall_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));

      served = 0;
      while (served < PHASE_ITEMS) begin
         // favor starting motion when idle and spinning once under way
         pick = $urandom_range(0, 99);
         if (seq_mode == MODE_IDLE) begin
            if (pick < 55)      op = OP_START;
            else if (pick < 70) op = OP_HOME;
            else if (pick < 85) op = OP_MOVE;
            else if (pick < 92) op = OP_SPIN;
            else if (pick < 96) op = OP_STOP;
            else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end else begin
            if (pick < 80)      op = OP_SPIN;
            else if (pick < 85) op = OP_START;
            else if (pick < 88) op = OP_HOME;
            else if (pick < 91) op = OP_MOVE;
            else if (pick < 96) op = OP_STOP;
            else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end
         if (op != OP_SPIN || $urandom_range(0, 99) < 4) begin
            ea = 1'($urandom_range(0, 1));
            eb = 1'($urandom_range(0, 1));
         end else begin
            ea = 1'b0;
            eb = 1'b0;
         end
         if ($urandom_range(0, 49) == 0) wall_ms = $urandom();
         else wall_ms = wall_ms + 32'($urandom_range(0, stride_max));
         ignored = (seq_mode == MODE_IDLE) && (op == OP_SPIN || op >= OP_SPARE_FIRST);
         send_request(op, 1'($urandom_range(0, 1)), ea, eb, wall_ms, 1'b0, NO_STATUS);
         if (!ignored) served++;
      end
   endtask

   // Accept status transactions with random back-pressure
   initial begin : status_monitor
      int      stall;
      rsp_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.mode         = rsp_bus.mode;
         got.forward      = rsp_bus.forward;
         got.step_request = rsp_bus.step_request;
         got.shutter      = rsp_bus.shutter;
         got.stopped      = rsp_bus.stopped;
         got.remaining_mm = rsp_bus.remaining_mm;
         got.wait_left_ms = rsp_bus.wait_left_ms;
         check_status(got);
      end
   end

   // Reset, directed table, random phases, then drain and report
   initial begin : stimulus
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= '0;
      req_bus.move_forward <= 1'b0;
      req_bus.end_stop_a   <= 1'b0;
      req_bus.end_stop_b   <= 1'b0;
      req_bus.now_ms       <= '0;
      reset_sequencer();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle_pipeline();
            write_reg(directed_rows[i].code, directed_rows[i].value[30:0]);
         end else begin
            send_request(directed_rows[i].code, directed_rows[i].mv, directed_rows[i].ea,
                         directed_rows[i].eb, directed_rows[i].value,
                         directed_rows[i].kind == ROW_TYPED, directed_rows[i].want);
            directed_sent++;
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) run_phase(phase);
      settle_pipeline();

      $display("Covered %0d requests (%0d directed) over %0d register writes, %0d checked.",
               requests_sent, directed_sent, settings_written, responses_checked);
      $display("Expected %0d step requests, %0d shutter firings and %0d returns to idle.",
               steps_seen, shutters_seen, stops_seen);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
